// File: hw/rtl/gsda_pkg.sv
// gsda_pkg: widths, constants, the cordic stage record and the elaboration-time
// arctangent and gain tables for the ground speed and drift angle block.
// No dependencies.
`default_nettype none

package gsda_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int FRAC_BITS     = 8;

   localparam int KT_W       = 24;
   localparam int KT_MAG_W   = KT_W - 1;
   localparam int KT_Q       = 24;
   localparam int KT_PROD_W  = KT_W + KT_Q;
   localparam logic [KT_Q-1:0] KT_PER_FPS_Q24 = KT_Q'(9940229);

   localparam int GUARD_BITS = 8;
   localparam int XY_W       = KT_W + GUARD_BITS + 3;
   localparam int ANG_FRAC   = 40;
   localparam int ANG_W      = ANG_FRAC + 10;
   localparam int ANG_SHIFT  = ANG_FRAC - FRAC_BITS;
   localparam int SHIFT_W    = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

   localparam int GAIN_W     = 30;
   localparam int PROD_W     = XY_W - 1 + GAIN_W;
   localparam int SPD_SHIFT  = GAIN_W + GUARD_BITS;
   localparam int SPD_W      = 23;
   localparam int ANGLE_W    = 17;

   localparam int REQ_DATA_W = 2 * KT_W;
   localparam int RSP_DATA_W = 2 * KT_W + SPD_W + ANGLE_W;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_IDX_SERVICEABLE = '0;

   typedef struct packed {
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [ANG_W-1:0] z;
      logic signed [KT_W-1:0]  fwd;
      logic signed [KT_W-1:0]  side;
      logic                    zero;
      logic                    neg;
      logic                    vneg;
   } cordic_type;

   // shift and subtract division, elaboration only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int k = 63; k >= 0; k--) begin
         rem = {rem[63:0], num[k]};
         quo = quo << 1;
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[0] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(1/d) in radians, q2.62
   function automatic logic [63:0] atan_recip(input logic [63:0] d);
      logic [63:0] p;
      logic [63:0] sum;
      logic [63:0] dd;
      logic [63:0] t;
      p   = udiv64(64'd1 << 62, d);
      sum = '0;
      dd  = d * d;
      for (int k = 0; k < 64; k++) begin
         if (p != 0) begin
            t = udiv64(p, 64'(2 * k + 1));
            if (k[0]) sum = sum - t;
            else sum = sum + t;
            p = udiv64(p, dd);
         end
      end
      return sum;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] num);
      logic [63:0] res;
      logic [63:0] bit_v;
      logic [63:0] n;
      n     = num;
      res   = '0;
      bit_v = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (bit_v > n) bit_v = bit_v >> 2;
      end
      for (int k = 0; k < 32; k++) begin
         if (bit_v != 0) begin
            if (n >= res + bit_v) begin
               n   = n - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return res;
   endfunction

   localparam logic [63:0] QUARTER_PI = 64'd4 * atan_recip(64'd5) - atan_recip(64'd239);

   // atan(2^-i) in degrees, 40 fraction bits, truncated
   function automatic logic [63:0] atan_deg_q40(input int i);
      logic [63:0] num;
      logic [63:0] q;
      num = '0;
      q   = '0;
      if (i == 0) return 64'd45 << ANG_FRAC;
      num = atan_recip(64'd1 << i);
      for (int b = 0; b < ANG_FRAC; b++) begin
         num = num << 1;
         q   = q << 1;
         if (num >= QUARTER_PI) begin
            num  = num - QUARTER_PI;
            q[0] = 1'b1;
         end
      end
      return q * 64'd45;
   endfunction

   // inverse cordic gain, q0.30, truncated
   function automatic logic [GAIN_W-1:0] gain_q30();
      logic [63:0] an2;
      an2 = 64'd1 << 60;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         if (2 * i < 64) an2 = an2 + (an2 >> (2 * i));
      end
      return GAIN_W'(udiv64(64'd1 << 60, isqrt64(an2)));
   endfunction

   localparam logic [GAIN_W-1:0] GAIN_Q30 = gain_q30();

endpackage

`default_nettype wire

// File: hw/rtl/gsda_scale.sv
// gsda_scale: converts ft/s to knots (multiply, then round) and sets up the
// first cordic vector with the half plane fold. Uses gsda_pkg.
`default_nettype none

module gsda_scale
   import gsda_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          serviceable,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic signed [KT_W-1:0]        fwd_fps,
   input  wire logic signed [KT_W-1:0]        side_fps,
   output logic                               out_valid,
   output cordic_type                         out_data,
   input  wire logic                          out_ready
);

   logic                  a_vld_ff;
   logic [KT_PROD_W-1:0]  a_prod_u_ff;
   logic [KT_PROD_W-1:0]  a_prod_v_ff;
   logic                  a_neg_u_ff;
   logic                  a_neg_v_ff;
   logic                  b_vld_ff;
   cordic_type            b_data_ff;

   logic                  a_ready;
   logic                  b_ready;
   logic [KT_W-1:0]       mag_fwd;
   logic [KT_W-1:0]       mag_side;
   logic [KT_PROD_W:0]    rnd_u;
   logic [KT_PROD_W:0]    rnd_v;
   logic [KT_MAG_W-1:0]   kt_u;
   logic [KT_MAG_W-1:0]   kt_v;
   logic signed [KT_W-1:0] kt_u_s;
   logic signed [KT_W-1:0] kt_v_s;
   logic signed [XY_W-1:0] kt_v_x;
   logic                  neg_in;
   cordic_type            b_data_in;

   assign b_ready  = !b_vld_ff || out_ready;
   assign a_ready  = !a_vld_ff || b_ready;
   assign in_ready = a_ready;

   assign mag_fwd  = fwd_fps[KT_W-1]  ? KT_W'(~fwd_fps + 1'b1)  : fwd_fps;
   assign mag_side = side_fps[KT_W-1] ? KT_W'(~side_fps + 1'b1) : side_fps;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (a_ready) begin
         a_vld_ff <= in_valid && serviceable;
      end
      if (a_ready) begin
         a_prod_u_ff <= KT_PROD_W'(mag_fwd) * KT_PROD_W'(KT_PER_FPS_Q24);
         a_prod_v_ff <= KT_PROD_W'(mag_side) * KT_PROD_W'(KT_PER_FPS_Q24);
         a_neg_u_ff  <= fwd_fps[KT_W-1];
         a_neg_v_ff  <= side_fps[KT_W-1];
      end
   end

   // round half away from zero on the magnitude
   assign rnd_u  = {1'b0, a_prod_u_ff} + ((KT_PROD_W+1)'(1) << (KT_Q - 1));
   assign rnd_v  = {1'b0, a_prod_v_ff} + ((KT_PROD_W+1)'(1) << (KT_Q - 1));
   assign kt_u   = rnd_u[KT_Q +: KT_MAG_W];
   assign kt_v   = rnd_v[KT_Q +: KT_MAG_W];
   assign kt_u_s = $signed({1'b0, kt_u});
   assign kt_v_s = $signed({1'b0, kt_v});
   assign kt_v_x = $signed(XY_W'(kt_v) << GUARD_BITS);
   assign neg_in = a_neg_u_ff && (kt_u != '0);

   always_comb begin
      b_data_in      = '0;
      b_data_in.fwd  = a_neg_u_ff ? -kt_u_s : kt_u_s;
      b_data_in.side = a_neg_v_ff ? -kt_v_s : kt_v_s;
      b_data_in.x    = $signed(XY_W'(kt_u) << GUARD_BITS);
      b_data_in.y    = (neg_in ^ a_neg_v_ff) ? -kt_v_x : kt_v_x;
      b_data_in.z    = '0;
      b_data_in.zero = (kt_u == '0) && (kt_v == '0);
      b_data_in.neg  = neg_in;
      b_data_in.vneg = a_neg_v_ff && (kt_v != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (b_ready) begin
         b_vld_ff <= a_vld_ff;
      end
      if (b_ready) begin
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_vld_ff;
   assign out_data  = b_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/gsda_cell.sv
// gsda_cell: one cordic vectoring rotation with its own stage register.
// Shift amount and arctangent come in as constants. Uses gsda_pkg.
`default_nettype none

module gsda_cell
   import gsda_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [SHIFT_W-1:0]      shift_amt,
   input  wire logic signed [ANG_W-1:0] atan_val,
   input  wire logic                    up_valid,
   output logic                         up_ready,
   input  wire cordic_type              up_data,
   output logic                         dn_valid,
   input  wire logic                    dn_ready,
   output cordic_type                   dn_data
);

   logic                   vld_ff;
   cordic_type             data_ff;
   cordic_type             data_in;
   logic signed [XY_W-1:0] xs;
   logic signed [XY_W-1:0] ys;

   assign up_ready = !vld_ff || dn_ready;
   assign xs       = up_data.x >>> shift_amt;
   assign ys       = up_data.y >>> shift_amt;

   always_comb begin
      data_in = up_data;
      if (!up_data.y[XY_W-1]) begin
         data_in.x = up_data.x + ys;
         data_in.y = up_data.y - xs;
         data_in.z = up_data.z + atan_val;
      end else begin
         data_in.x = up_data.x - ys;
         data_in.y = up_data.y + xs;
         data_in.z = up_data.z - atan_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (up_ready) begin
         vld_ff <= up_valid;
      end
      if (up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = vld_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/gsda_post.sv
// gsda_post: gain correction, rounding, angle clamp and the output register
// with its skid stage. Uses gsda_pkg.
`default_nettype none

module gsda_post
   import gsda_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  up_valid,
   output logic                       up_ready,
   input  wire cordic_type            up_data,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   localparam logic signed [ANG_W-1:0] BASE_180 = ANG_W'(180) << ANG_FRAC;
   localparam logic signed [ANG_W-1:0] ANG_HALF = ANG_W'(1) << (ANG_SHIFT - 1);
   localparam logic signed [ANG_W-1:0] ANG_LIM  = ANG_W'(180) << FRAC_BITS;
   localparam logic [PROD_W:0]         SPD_HALF = (PROD_W+1)'(1) << (SPD_SHIFT - 1);
   localparam logic [PROD_W:0]         SPD_MAX  = (PROD_W+1)'({SPD_W{1'b1}});

   logic                    m_vld_ff;
   logic [PROD_W-1:0]       m_prod_ff;
   logic signed [ANG_W-1:0] m_ang_ff;
   logic                    m_zero_ff;
   logic signed [KT_W-1:0]  m_fwd_ff;
   logic signed [KT_W-1:0]  m_side_ff;
   logic                    f_vld_ff;
   logic [RSP_DATA_W-1:0]   f_data_ff;
   logic                    o_vld_ff;
   logic [RSP_DATA_W-1:0]   o_data_ff;
   logic                    s_vld_ff;
   logic [RSP_DATA_W-1:0]   s_data_ff;

   logic                    m_ready;
   logic                    f_ready;
   logic                    f_take;
   logic [XY_W-2:0]         xc;
   logic signed [ANG_W-1:0] base;
   logic [PROD_W:0]         spd_full;
   logic [SPD_W-1:0]        spd;
   logic signed [ANG_W-1:0] ang_sh;
   logic signed [ANG_W-1:0] ang_clamp;
   logic [RSP_DATA_W-1:0]   f_data_in;

   assign f_take   = f_vld_ff && !s_vld_ff;
   assign f_ready  = !f_vld_ff || !s_vld_ff;
   assign m_ready  = !m_vld_ff || f_ready;
   assign up_ready = m_ready;

   assign xc = up_data.x[XY_W-1] ? '0 : up_data.x[XY_W-2:0];

   always_comb begin
      if (!up_data.neg) begin
         base = '0;
      end else if (up_data.vneg) begin
         base = -BASE_180;
      end else begin
         base = BASE_180;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else if (m_ready) begin
         m_vld_ff <= up_valid;
      end
      if (m_ready) begin
         m_prod_ff <= PROD_W'(xc) * PROD_W'(GAIN_Q30);
         m_ang_ff  <= base + up_data.z + ANG_HALF;
         m_zero_ff <= up_data.zero;
         m_fwd_ff  <= up_data.fwd;
         m_side_ff <= up_data.side;
      end
   end

   assign spd_full = ({1'b0, m_prod_ff} + SPD_HALF) >> SPD_SHIFT;
   assign spd      = (spd_full > SPD_MAX) ? {SPD_W{1'b1}} : spd_full[SPD_W-1:0];
   assign ang_sh   = m_ang_ff >>> ANG_SHIFT;

   always_comb begin
      if (ang_sh > ANG_LIM) begin
         ang_clamp = ANG_LIM;
      end else if (ang_sh < -ANG_LIM) begin
         ang_clamp = -ANG_LIM;
      end else begin
         ang_clamp = ang_sh;
      end
      if (m_zero_ff) begin
         f_data_in = {{(ANGLE_W + SPD_W){1'b0}}, m_side_ff, m_fwd_ff};
      end else begin
         f_data_in = {ang_clamp[ANGLE_W-1:0], spd, m_side_ff, m_fwd_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (f_ready) begin
         f_vld_ff <= m_vld_ff;
      end
      if (f_ready) begin
         f_data_ff <= f_data_in;
      end
   end

   // output register and skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
         s_vld_ff <= 1'b0;
      end else if (rsp_tready || !o_vld_ff) begin
         o_vld_ff <= s_vld_ff || f_take;
         s_vld_ff <= 1'b0;
      end else if (f_take) begin
         s_vld_ff <= 1'b1;
      end
      if (rsp_tready || !o_vld_ff) begin
         o_data_ff <= s_vld_ff ? s_data_ff : f_data_ff;
      end else if (f_take) begin
         s_data_ff <= f_data_ff;
      end
   end

   assign rsp_tvalid = o_vld_ff;
   assign rsp_tdata  = o_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/ground_speed_drift_angle_top.sv
// ground_speed_drift_angle_top: ft/s velocity pair in, knots, ground speed and
// drift angle out. Uses gsda_pkg, gsda_scale, gsda_cell and gsda_post.
//
// req channel: one transfer carries the forward and lateral body velocities in
// ft/s (signed, 8 fraction bits). rsp channel: one transfer carries both
// components in knots, the ground speed and the drift angle atan2(side, fwd)
// in degrees (8 fraction bits, -180 to +180).
// csr port: register 0 bit 0 is serviceable (reset 1); while it is clear,
// accepted transfers are dropped and give no result.
// From req transfer to rsp_tvalid the stages are knot multiply, rounding and
// fold, one cell per cordic rotation, gain multiply, rounding and clamp, and
// the output register. Throughput is one transfer per cycle when rsp_tready
// is high; every stage holds one item and the cordic rotations are a chain
// of cells passing the vector on each cycle.
// When rsp_tready is low the output register and its skid stage hold results
// while the chain keeps filling its empty stages; req_tready drops only once
// every stage is occupied. req_tready depends on registered state only.
// Synchronous reset empties every stage and sets serviceable.
`default_nettype none

module ground_speed_drift_angle_top
   import gsda_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,   // fwd_speed_fps, side_speed_fps
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,   // fwd_speed_kt, side_speed_kt,
                                                    // ground_speed_kt, drift_angle_deg
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]       csr_prdata,
   output logic                        csr_pready
);

   logic                        serviceable_ff;
   logic [CSR_ADDR_W-3:0]       csr_idx;
   logic [CORDIC_STAGES:0]      cell_vld;
   logic [CORDIC_STAGES:0]      cell_rdy;
   cordic_type                  cell_dat [CORDIC_STAGES+1];

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         serviceable_ff <= 1'b1;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_idx == CSR_IDX_SERVICEABLE) begin
         serviceable_ff <= csr_pwdata[0];
      end
   end

   assign csr_prdata = (csr_idx == CSR_IDX_SERVICEABLE)
                       ? {{(CSR_DATA_W-1){1'b0}}, serviceable_ff} : '0;

   gsda_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .serviceable (serviceable_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .fwd_fps     (req_tdata[KT_W-1:0]),
      .side_fps    (req_tdata[2*KT_W-1:KT_W]),
      .out_valid   (cell_vld[0]),
      .out_data    (cell_dat[0]),
      .out_ready   (cell_rdy[0])
   );

   for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cell
      localparam logic [SHIFT_W-1:0]      SHIFT_I = SHIFT_W'(gi);
      localparam logic signed [ANG_W-1:0] ATAN_I  = ANG_W'(atan_deg_q40(gi));

      gsda_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_amt (SHIFT_I),
         .atan_val  (ATAN_I),
         .up_valid  (cell_vld[gi]),
         .up_ready  (cell_rdy[gi]),
         .up_data   (cell_dat[gi]),
         .dn_valid  (cell_vld[gi+1]),
         .dn_ready  (cell_rdy[gi+1]),
         .dn_data   (cell_dat[gi+1])
      );
   end

   gsda_post u_post (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (cell_vld[CORDIC_STAGES]),
      .up_ready   (cell_rdy[CORDIC_STAGES]),
      .up_data    (cell_dat[CORDIC_STAGES]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: hw/rtl/gsda_checker.sv
// gsda_checker: port-level checks on the top level, attached by bind.
// Uses gsda_pkg; sees ground_speed_drift_angle_top ports only.
`default_nettype none

module gsda_checker
   import gsda_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_DATA_W-1:0]  rsp_tdata
);

   logic signed [ANGLE_W-1:0] angle;
   assign angle = $signed(rsp_tdata[RSP_DATA_W-1 -: ANGLE_W]);

   // stalled transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transfer changed while stalled");

   // zero velocity gives zero speed and angle
   a_zero_vec: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2*KT_W-1:0] == '0
      |-> rsp_tdata[RSP_DATA_W-1:2*KT_W] == '0)
      else $error("zero vector gave nonzero speed or angle");

   // angle stays within half a turn
   a_angle_rng: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> angle <= 17'sd46080 && angle >= -17'sd46080)
      else $error("drift angle out of range");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present after reset");

endmodule

bind ground_speed_drift_angle_top gsda_checker u_gsda_checker (.*);

`default_nettype wire
